// ===== sv/sha512_hash_core_macros.svh =====
// Assertion macros for the SHA-512 hash core.
`ifndef SHA512_HASH_CORE_MACROS_SVH
`define SHA512_HASH_CORE_MACROS_SVH
// Assert that a property holds on every clock edge out of reset.
`define SHC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m: lbl");
// Assert that an antecedent implies a consequent in the next cycle.
`define SHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: lbl");
`endif

// ===== sv/shc_pkg.sv =====
// Package with types, constants and functions of the SHA-512 hash core.
package shc_pkg;

    localparam int WORD_W = 64;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    // Sources for the word pushed into the block.
    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_ZERO,
        SRC_PADONLY,
        SRC_LEN_HI,
        SRC_LEN_LO
    } t_src;

    typedef struct packed {
        logic       push;
        t_src       src;
        logic       add_bytes;
        logic       start;
        logic       round;
        logic       finish;
        logic       reset_hash;
    } t_cmd;

    typedef struct packed {
        logic [3:0] fill;
        logic       last_round;
    } t_status;

    localparam t_word HINIT [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam t_word RCONST [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

// ===== sv/sha512_hash_core.sv =====
// Top level of the SHA-512 hash core.
// Non-final word: accepted while idle; a block's 16th word also starts the 80 rounds and then
// the hash update (the state load overlaps the accept), and no word is taken until they end.
// Final word: padding pushes and one or two compressions, then 8 digest transactions.
// Synchronous active-low reset loads the initial hash and clears counters.
module sha512_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_digest
);
    import shc_pkg::*;

    t_cmd    cmd;
    t_status status;

    shc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_valid_bytes, .i_last_word, .i_ready,
        .o_in_ready(o_ready), .o_out_valid(o_valid), .o_word_index,
        .o_cmd(cmd), .i_status(status)
    );

    shc_datapath u_dp (
        .i_clk, .i_rst_n, .i_message_word, .i_valid_bytes, .i_last_word,
        .i_cmd(cmd), .i_word_index(o_word_index), .o_status(status), .o_digest_word
    );

    assign o_last_digest = (o_word_index == 3'd7);
endmodule

// ===== sv/shc_ctrl.sv =====
// Controller state machine of the SHA-512 hash core.
module shc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [3:0]        i_valid_bytes,
    input  logic              i_last_word,
    input  logic              i_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_word_index,
    output shc_pkg::t_cmd     o_cmd,
    input  shc_pkg::t_status  i_status
);
    import shc_pkg::*;

    t_state     r_state, n_state;
    logic       r_padded, n_padded;   // 0x80 byte already placed
    logic       r_final, n_final;     // current block run ends the message
    logic       r_len, n_len;         // length high word placed
    logic [2:0] r_idx, n_idx;
    logic       acc;

    assign acc = i_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_padded <= 1'b0;
            r_final  <= 1'b0;
            r_len    <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_padded <= n_padded;
            r_final  <= n_final;
            r_len    <= n_len;
            r_idx    <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_padded    = r_padded;
        n_final     = r_final;
        n_len       = r_len;
        n_idx       = r_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.src   = SRC_INPUT;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (acc) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.add_bytes = 1'b1;
                    if (i_last_word) begin
                        n_final  = 1'b1;
                        n_padded = (i_valid_bytes < 4'd8);
                    end
                    if (i_status.fill == 4'd15) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_ROUND;
                    end else if (i_last_word) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.push = 1'b1;
                if (!r_padded) begin
                    o_cmd.src = SRC_PADONLY;
                    n_padded  = 1'b1;
                end else if (i_status.fill == 4'd14) begin
                    o_cmd.src = SRC_LEN_HI;
                    n_len     = 1'b1;
                end else if (i_status.fill == 4'd15 && r_len) begin
                    o_cmd.src = SRC_LEN_LO;
                end else begin
                    o_cmd.src = SRC_ZERO;
                end
                if (i_status.fill == 4'd15) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.last_round) n_state = ST_FINAL;
            end
            ST_FINAL: begin
                o_cmd.finish = 1'b1;
                if (!r_final) begin
                    n_state = ST_IDLE;
                end else if (!r_len) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_OUT;
                    n_idx   = '0;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.reset_hash = 1'b1;
                        n_final  = 1'b0;
                        n_padded = 1'b0;
                        n_len    = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_word_index = r_idx;

    `include "sha512_hash_core_macros.svh"
    `SHC_ASSERT(a_out_only_final, i_clk, i_rst_n, !o_out_valid || r_final)
    `SHC_ASSERT(a_ready_idle, i_clk, i_rst_n, !o_in_ready || r_state == ST_IDLE)
    `SHC_ASSERT_NEXT(a_last_round, i_clk, i_rst_n, r_state == ST_ROUND && i_status.last_round, r_state == ST_FINAL)
endmodule

// ===== sv/shc_datapath.sv =====
// Datapath of the SHA-512 hash core: block buffer, schedule, rounds, hash state.
module shc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [63:0]       i_message_word,
    input  logic [3:0]        i_valid_bytes,
    input  logic              i_last_word,
    input  shc_pkg::t_cmd     i_cmd,
    input  logic [2:0]        i_word_index,
    output shc_pkg::t_status  o_status,
    output logic [63:0]       o_digest_word
);
    import shc_pkg::*;

    t_word      r_w [16];
    t_word      r_v [8];
    t_word      r_h [8];
    logic [63:0] r_bytes;
    logic [3:0]  r_fill;
    logic [6:0]  r_t;

    logic [3:0]  nb;
    t_word       keep, inword, pword;
    logic [63:0] n_bytes;
    t_word       w2, w15, s0, s1, wt, t1, t2, e, a;
    logic [3:0]  ti;

    always_comb begin
        nb = (!i_last_word) ? 4'd8 : ((i_valid_bytes > 4'd8) ? 4'd8 : i_valid_bytes);
        keep = (nb == 4'd0) ? '0 : ~(64'hffffffffffffffff >> {nb, 3'b000});
        if (nb == 4'd8) inword = i_message_word;
        else inword = (i_message_word & keep) | (64'h8000000000000000 >> {nb, 3'b000});
        n_bytes = r_bytes + {60'd0, nb};
        case (i_cmd.src)
            SRC_INPUT:   pword = inword;
            SRC_PADONLY: pword = 64'h8000000000000000;
            SRC_LEN_HI:  pword = {61'd0, r_bytes[63:61]};
            SRC_LEN_LO:  pword = {r_bytes[60:0], 3'b000};
            default:     pword = '0;
        endcase
    end

    always_comb begin
        ti  = r_t[3:0];
        w2  = r_w[ti - 4'd2];
        w15 = r_w[ti - 4'd15];
        s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
        s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
        wt  = (r_t < 7'd16) ? r_w[ti] : (s1 + r_w[ti - 4'd7] + s0 + r_w[ti]);
        e   = r_v[4];
        a   = r_v[0];
        t1  = r_v[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
            + ((e & r_v[5]) ^ (~e & r_v[6])) + RCONST[r_t] + wt;
        t2  = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
            + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_bytes <= '0;
            r_t     <= '0;
            for (int k = 0; k < 8; k++) r_h[k] <= HINIT[k];
        end else begin
            if (i_cmd.push) begin
                r_w[r_fill] <= pword;
                r_fill      <= r_fill + 4'd1;
            end
            if (i_cmd.add_bytes) r_bytes <= n_bytes;
            if (i_cmd.start) begin
                r_t <= '0;
                for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
            end
            if (i_cmd.round) begin
                r_w[ti] <= wt;
                r_t     <= r_t + 7'd1;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            if (i_cmd.finish) begin
                for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
            end
            if (i_cmd.reset_hash) begin
                for (int k = 0; k < 8; k++) r_h[k] <= HINIT[k];
                r_bytes <= '0;
                r_fill  <= '0;
            end
        end
    end

    assign o_status.fill       = r_fill;
    assign o_status.last_round = (r_t == 7'd79);
    assign o_digest_word       = r_h[i_word_index];

    `include "sha512_hash_core_macros.svh"
    `SHC_ASSERT(a_no_push_round, i_clk, i_rst_n, !(i_cmd.push && i_cmd.round))
    `SHC_ASSERT_NEXT(a_start_t0, i_clk, i_rst_n, i_cmd.start, r_t == 7'd0 && r_fill == 4'd0)
endmodule
